/* hdl/fwbs_pkg.sv */
// shared constants and types for the flag weighted box smoother
package fwbs_pkg;

    localparam int MAX_ROWS_DEF    = 1024;
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int POS_BITS        = 11;
    localparam int IDX_BITS        = 2;

    localparam logic [IDX_BITS-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_COLUMN_COUNT = 2'd1;

    // one output slot produced by the front end
    typedef struct packed {
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] column;
        logic                is_border;
    } t_slot;

    // control info passed from front to back per input item
    typedef struct packed {
        logic [3:0] slot_valid;
        t_slot      s0;
        t_slot      s1;
        t_slot      s2;
        t_slot      s3;
        logic       use_mean;
    } t_job;

endpackage

/* hdl/fwbs_ram.sv */
// generic single write, single read ram with registered read
module fwbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/fwbs_front.sv */
// front end: position tracking, line stores, window and classification
module fwbs_front #(
    parameter int MAX_ROWS    = fwbs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = fwbs_pkg::MAX_COLUMNS_DEF,
    parameter int SAMPLE_BITS = fwbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fwbs_pkg::IDX_BITS-1:0]      i_cfg_index,
    input  logic [fwbs_pkg::POS_BITS-1:0]      i_cfg_data,
    input  logic                               i_push,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_stall,
    output logic                               o_busy,
    output logic                               o_valid,
    output fwbs_pkg::t_job                     o_job,
    output logic signed [SAMPLE_BITS-1:0]      o_centre,
    output logic signed [SAMPLE_BITS+3:0]      o_sum
);
    localparam int PB = fwbs_pkg::POS_BITS;
    localparam int CB = $clog2(MAX_COLUMNS);
    localparam int SB = SAMPLE_BITS;
    localparam logic [PB-1:0] MAXR = PB'(MAX_ROWS);
    localparam logic [PB-1:0] MAXC = PB'(MAX_COLUMNS);
    localparam logic [PB-1:0] ONE = PB'(1);

    logic [PB-1:0] r_row_count, r_col_count, r_row, r_col;

    // stage a: accepted sample with its position, line store read launched
    logic          r_a_valid;
    logic [PB-1:0] r_a_row, r_a_col;
    logic signed [SB-1:0] r_a_sample;
    logic signed [SB-1:0] w_up, w_mid;

    logic signed [SB-1:0] r_win [6];
    logic r_b_valid;
    fwbs_pkg::t_job r_b_job, n_job;
    logic signed [SB-1:0] r_b_centre;
    logic signed [SB+3:0] r_b_sum;

    function automatic logic [PB-1:0] clampv(input logic [PB-1:0] v,
                                             input logic [PB-1:0] mx);
        if (v == '0) return ONE;
        if (v > mx) return mx;
        return v;
    endfunction

    // the pipeline moves only when the back end has room
    logic w_adv;
    assign w_adv = !i_stall;
    assign o_busy = i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= MAXR;
            r_col_count <= MAXC;
            r_row <= ONE;
            r_col <= ONE;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fwbs_pkg::REG_ROW_COUNT) begin
                r_row_count <= clampv(i_cfg_data, MAXR);
                r_row <= ONE;
                r_col <= ONE;
            end else if (i_cfg_index == fwbs_pkg::REG_COLUMN_COUNT) begin
                r_col_count <= clampv(i_cfg_data, MAXC);
                r_row <= ONE;
                r_col <= ONE;
            end
        end else if (i_push) begin
            if (r_col >= r_col_count) begin
                r_col <= ONE;
                r_row <= (r_row >= r_row_count) ? ONE : r_row + ONE;
            end else begin
                r_col <= r_col + ONE;
            end
        end
    end

    logic [CB-1:0] w_raddr, w_waddr;
    assign w_raddr = CB'(r_col - ONE);
    assign w_waddr = CB'(r_a_col - ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_push;
        end
        if (w_adv && i_push) begin
            r_a_row <= r_row;
            r_a_col <= r_col;
            r_a_sample <= i_sample;
        end
    end

    // read while pushing; the previous item's write can hit the same column only
    // when a row has one column (C=1), and the forwarding below covers that case
    logic signed [SB-1:0] r_up_hold, r_mid_hold;
    logic r_same;
    logic signed [SB-1:0] w_upr, w_midr, w_cur0, w_cur1;
    fwbs_ram #(.WIDTH(SB), .DEPTH(MAX_COLUMNS)) u_upper (
        .i_clk(i_clk), .i_we(w_adv && r_a_valid), .i_waddr(w_waddr),
        .i_wdata(w_cur1), .i_re(w_adv && i_push), .i_raddr(w_raddr),
        .o_rdata(w_upr)
    );
    fwbs_ram #(.WIDTH(SB), .DEPTH(MAX_COLUMNS)) u_middle (
        .i_clk(i_clk), .i_we(w_adv && r_a_valid), .i_waddr(w_waddr),
        .i_wdata(r_a_sample), .i_re(w_adv && i_push), .i_raddr(w_raddr),
        .o_rdata(w_midr)
    );

    // forward the previous item's write when it hit the same column
    always_ff @(posedge i_clk) begin
        if (w_adv && i_push) begin
            r_same <= r_a_valid && (w_waddr == w_raddr);
            r_up_hold <= w_cur1;
            r_mid_hold <= r_a_sample;
        end
    end
    assign w_up  = r_same ? r_up_hold : w_upr;
    assign w_mid = r_same ? r_mid_hold : w_midr;
    assign w_cur0 = w_up;
    assign w_cur1 = w_mid;

    logic w_h, w_a, w_b, w_c;
    logic [PB-1:0] w_hr, w_hc;
    logic signed [SB+3:0] w_sum;

    function automatic logic bord(input logic [PB-1:0] r, input logic [PB-1:0] c,
                                  input logic [PB-1:0] rr, input logic [PB-1:0] cc);
        logic [PB:0] re, ce;
        re = {1'b0, r} + (PB+1)'(3);
        ce = {1'b0, c} + (PB+1)'(3);
        return (r < PB'(3)) || (re > {1'b0, rr}) || (c < PB'(3)) || (ce > {1'b0, cc});
    endfunction

    always_comb begin
        w_hr = r_a_row - ONE;
        w_hc = r_a_col - ONE;
        w_h = (r_a_row >= PB'(2)) && (r_a_col >= PB'(2));
        w_a = (r_a_row >= PB'(2)) && (r_a_col == r_col_count);
        w_b = (r_a_row == r_row_count) && (r_a_col >= PB'(2));
        w_c = (r_a_row == r_row_count) && (r_a_col == r_col_count);
        n_job = '0;
        n_job.slot_valid = {w_c, w_b, w_a, w_h};
        n_job.s0 = '{row: w_hr, column: w_hc, is_border: bord(w_hr, w_hc,
                     r_row_count, r_col_count)};
        n_job.s1 = '{row: w_hr, column: r_col_count, is_border: 1'b1};
        n_job.s2 = '{row: r_row_count, column: w_hc, is_border: 1'b1};
        n_job.s3 = '{row: r_row_count, column: r_col_count, is_border: 1'b1};
        n_job.use_mean = (r_win[4] == SB'(256)) || (r_win[4] == -SB'(256));
        w_sum = (SB+4)'(w_cur0) + (SB+4)'(w_cur1) + (SB+4)'(r_a_sample)
              + (SB+4)'(r_win[0]) + (SB+4)'(r_win[1]) + (SB+4)'(r_win[2])
              + (SB+4)'(r_win[3]) + (SB+4)'(r_win[4]) + (SB+4)'(r_win[5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid && (n_job.slot_valid != '0);
            if (r_a_valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= w_cur0;
                r_win[4] <= w_cur1;
                r_win[5] <= r_a_sample;
            end
        end
        if (w_adv && r_a_valid) begin
            r_b_job <= n_job;
            r_b_centre <= r_win[4];
            r_b_sum <= w_sum;
        end
    end

    assign o_valid = r_b_valid;
    assign o_job = r_b_job;
    assign o_centre = r_b_centre;
    assign o_sum = r_b_sum;
endmodule

/* hdl/fwbs_back.sv */
// back end: constant division and a job queue whose head also serves the results
module fwbs_back #(
    parameter int SAMPLE_BITS = fwbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  fwbs_pkg::t_job                i_job,
    input  logic signed [SAMPLE_BITS-1:0] i_centre,
    input  logic signed [SAMPLE_BITS+3:0] i_sum,
    output logic                          o_stall,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [fwbs_pkg::POS_BITS-1:0] o_out_row,
    output logic [fwbs_pkg::POS_BITS-1:0] o_out_column,
    output logic signed [SAMPLE_BITS-1:0] o_smoothed,
    output logic                          o_is_border,
    output logic                          o_last_of_run
);
    localparam int SB = SAMPLE_BITS;
    localparam int QD = 4;
    localparam int QB = 2;

    // reciprocal constants, four spare shift bits keep the quotient exact
    localparam int          DN9  = SB + 3;
    localparam int          SH9  = DN9 + 4;
    localparam int          MB9  = SH9 - 3;
    localparam logic [63:0] M9   = ((64'd1 << SH9) + 64'd8) / 64'd9;
    localparam int          SH10 = SB + 4;
    localparam int          MB10 = SH10 - 3;
    localparam logic [63:0] M10  = ((64'd1 << SH10) + 64'd9) / 64'd10;

    // job queue: holds front results so the front runs ahead of slot draining
    fwbs_pkg::t_job       r_q_job [QD];
    logic signed [SB-1:0] r_q_val [QD];
    logic [QB-1:0] r_wp, r_rp;
    logic [QB:0]   r_cnt;
    logic [3:0]    r_done, n_done;

    // division by constants on the magnitude, sign put back after
    logic                 w_neg9, w_neg10;
    logic [SB+3:0]        w_mag9;
    logic [SB-1:0]        w_mag10;
    logic [DN9+MB9-1:0]   w_p9;
    logic [SB+MB10-1:0]   w_p10;
    logic [SB-1:0]        w_q9;
    logic [SB-4:0]        w_q10;
    logic signed [SB-1:0] w_mean, w_tenth, w_val;

    assign w_neg9  = i_sum[SB+3];
    assign w_mag9  = w_neg9 ? -i_sum : i_sum;
    assign w_p9    = w_mag9[DN9-1:0] * M9[MB9-1:0];
    assign w_q9    = w_p9[DN9+MB9-1:SH9];
    assign w_mean  = w_neg9 ? -$signed(w_q9) : $signed(w_q9);

    assign w_neg10 = i_centre[SB-1];
    assign w_mag10 = w_neg10 ? -i_centre : i_centre;
    assign w_p10   = w_mag10 * M10[MB10-1:0];
    assign w_q10   = w_p10[SB+MB10-1:SH10];
    assign w_tenth = w_neg10 ? -$signed({3'b000, w_q10}) : $signed({3'b000, w_q10});

    assign w_val = i_job.use_mean ? w_mean : w_tenth;

    logic w_take, w_pend, w_slot_pop, w_last;
    logic [1:0] w_sel;
    fwbs_pkg::t_job w_head;
    fwbs_pkg::t_slot w_s;
    logic [3:0] w_left;

    assign o_stall = (r_cnt >= (QB+1)'(QD - 1));
    assign w_take = i_valid;
    assign w_head = r_q_job[r_rp];
    assign w_pend = (r_cnt != '0);

    always_comb begin
        w_left = w_head.slot_valid & ~r_done;
        w_sel = 2'd0;
        w_s = w_head.s0;
        if (w_left[0]) begin
            w_sel = 2'd0; w_s = w_head.s0;
        end else if (w_left[1]) begin
            w_sel = 2'd1; w_s = w_head.s1;
        end else if (w_left[2]) begin
            w_sel = 2'd2; w_s = w_head.s2;
        end else begin
            w_sel = 2'd3; w_s = w_head.s3;
        end
        n_done = r_done;
        n_done[w_sel] = 1'b1;
        w_last = ((w_head.slot_valid & ~n_done) == 4'd0);
    end

    assign o_empty = !w_pend;
    assign w_slot_pop = w_pend && i_pop;
    assign o_out_row = w_s.row;
    assign o_out_column = w_s.column;
    assign o_is_border = w_s.is_border;
    assign o_smoothed = (w_s.is_border) ? '0 : r_q_val[r_rp];
    assign o_last_of_run = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_done <= '0;
        end else begin
            if (w_take) r_wp <= r_wp + 1'b1;
            if (w_slot_pop) begin
                if (w_last) begin
                    r_rp <= r_rp + 1'b1;
                    r_done <= '0;
                end else begin
                    r_done <= n_done;
                end
            end
            r_cnt <= r_cnt + (QB+1)'(w_take) - (QB+1)'(w_slot_pop && w_last);
        end
        if (w_take) begin
            r_q_job[r_wp] <= i_job;
            r_q_val[r_wp] <= w_val;
        end
    end
endmodule

/* hdl/flag_weighted_box_smoother.sv */
// top level of the flag weighted box smoother
//  channel   | handshake              | payload
//  input     | i_push / o_full        | i_sample
//  result    | o_empty / i_pop        | o_out_row o_out_column o_smoothed o_is_border o_last_of_run
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
// one sample a cycle while o_full is low; a result passes the line store read, the window
// sum and the job queue before it leaves; a sample giving several results holds the head
// of the job queue for as many pops. o_full rises while the job queue is near full.
// reset sets both counts to their maxima and the position to (1,1); no clearing pass.
module flag_weighted_box_smoother #(
    parameter int MAX_ROWS    = fwbs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = fwbs_pkg::MAX_COLUMNS_DEF,
    parameter int SAMPLE_BITS = fwbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [fwbs_pkg::POS_BITS-1:0] o_out_row,
    output logic [fwbs_pkg::POS_BITS-1:0] o_out_column,
    output logic signed [SAMPLE_BITS-1:0] o_smoothed,
    output logic                          o_is_border,
    output logic                          o_last_of_run,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fwbs_pkg::IDX_BITS-1:0] i_cfg_index,
    input  logic [fwbs_pkg::POS_BITS-1:0] i_cfg_data
);
    logic w_stall, w_busy, w_valid;
    fwbs_pkg::t_job w_job;
    logic signed [SAMPLE_BITS-1:0] w_centre;
    logic signed [SAMPLE_BITS+3:0] w_sum;

    assign o_full = w_busy;
    assign o_cfg_ready = 1'b1;

    fwbs_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS),
                 .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_push(i_push && !w_busy), .i_sample(i_sample), .i_stall(w_stall),
        .o_busy(w_busy), .o_valid(w_valid), .o_job(w_job),
        .o_centre(w_centre), .o_sum(w_sum)
    );

    fwbs_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_valid && !w_stall), .i_job(w_job), .i_centre(w_centre),
        .i_sum(w_sum), .o_stall(w_stall), .o_empty(o_empty), .i_pop(i_pop),
        .o_out_row(o_out_row), .o_out_column(o_out_column),
        .o_smoothed(o_smoothed), .o_is_border(o_is_border),
        .o_last_of_run(o_last_of_run)
    );
endmodule

/* hdl/fwbs_checker.sv */
// port level checks for the flag weighted box smoother
module fwbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [10:0] o_out_row,
    input logic [10:0] o_out_column,
    input logic        o_is_border
);
    a_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_out_row != 11'd0) else $error("row zero");
    a_col_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_out_column != 11'd0) else $error("column zero");
    a_edge_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_out_row < 11'd3 || o_out_column < 11'd3)) |-> o_is_border)
        else $error("edge not flagged");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> !o_empty) else $error("result lost");
endmodule

bind flag_weighted_box_smoother fwbs_checker u_fwbs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_empty(o_empty), .i_pop(i_pop),
    .o_out_row(o_out_row), .o_out_column(o_out_column), .o_is_border(o_is_border)
);
